/* hw/rtl/mtsbvm_pkg.sv */
// Package with the request types, codes and instruction decode of the bytecode machine.
package mtsbvm_pkg;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] address;
        logic [7:0] write_data;
        logic       sense_left;
        logic       sense_right;
    } in_t;

    typedef struct packed {
        logic       motor_left;
        logic       motor_right;
        logic [7:0] read_data;
    } out_t;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_RESTART = 2'd3;

    localparam logic [2:0] CFG_ACTIVE_MASK = 3'd0;
    localparam logic [2:0] CFG_START0      = 3'd1;
    localparam logic [2:0] CFG_START3      = 3'd4;

    localparam logic [7:0] OP_ORG  = 8'd1;
    localparam logic [7:0] OP_EQU  = 8'd2;
    localparam logic [7:0] OP_JMP  = 8'd3;
    localparam logic [7:0] OP_JMPZ = 8'd4;
    localparam logic [7:0] OP_PSHL = 8'd5;
    localparam logic [7:0] OP_PSH  = 8'd6;
    localparam logic [7:0] OP_PSHI = 8'd7;
    localparam logic [7:0] OP_POP  = 8'd8;
    localparam logic [7:0] OP_POPI = 8'd9;
    localparam logic [7:0] OP_ADD  = 8'd10;
    localparam logic [7:0] OP_SUB  = 8'd11;
    localparam logic [7:0] OP_INC  = 8'd12;
    localparam logic [7:0] OP_DEC  = 8'd13;
    localparam logic [7:0] OP_AND  = 8'd14;
    localparam logic [7:0] OP_OR   = 8'd15;
    localparam logic [7:0] OP_XOR  = 8'd16;
    localparam logic [7:0] OP_NOT  = 8'd17;
    localparam logic [7:0] OP_ROR  = 8'd18;
    localparam logic [7:0] OP_ROL  = 8'd19;
    localparam logic [7:0] OP_PIP  = 8'd20;
    localparam logic [7:0] OP_PDP  = 8'd21;
    localparam logic [7:0] OP_DUP  = 8'd22;
    localparam logic [7:0] OP_LMOT = 8'd23;
    localparam logic [7:0] OP_RMOT = 8'd24;
    localparam logic [7:0] OP_LEYE = 8'd25;
    localparam logic [7:0] OP_REYE = 8'd26;

    // Work plan of one instruction: operand fetch, indirect reads, pops.
    typedef struct packed {
        logic       opnd;
        logic [1:0] nind;
        logic [1:0] npop;
        logic       peek;
    } ctl_t;

    function automatic ctl_t decode(input logic [7:0] op);
        ctl_t c;
        c = '0;
        case (op) inside
            OP_JMP, OP_PSHL:               c.opnd = 1'b1;
            OP_JMPZ, OP_POP, OP_ROR, OP_ROL:
            begin
                c.opnd = 1'b1;
                c.npop = 2'd1;
            end
            OP_PSH, OP_PIP, OP_PDP:
            begin
                c.opnd = 1'b1;
                c.nind = 2'd1;
            end
            OP_PSHI:
            begin
                c.opnd = 1'b1;
                c.nind = 2'd2;
            end
            OP_POPI:
            begin
                c.opnd = 1'b1;
                c.nind = 2'd1;
                c.npop = 2'd1;
            end
            OP_EQU, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: c.npop = 2'd2;
            OP_INC, OP_DEC, OP_NOT, OP_LMOT, OP_RMOT:      c.npop = 2'd1;
            OP_DUP:
            begin
                c.npop = 2'd1;
                c.peek = 1'b1;
            end
            default:                       c = '0;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/multithread_stack_bytecode_vm.sv */
// Top level of the multithreaded byte-coded stack machine.
//
// Usage: requests enter on in_valid/in_data and are taken when in_stall is
// low; results leave on out_valid/out_data and are taken when out_stall is
// low. Configuration registers are written on cfg_valid/cfg_index/cfg_data,
// always ready; the user must write them only while the block is idle, which
// the block itself does not enforce. A tick request runs one instruction on
// every active thread in index order and returns the motor bits; a read
// request returns one heap byte; write and restart requests return nothing.
// The block works on one request at a time and raises in_stall until it is
// done. Every heap or stack access goes through the single registered read
// port of its memory, one dependent access after another, so an instruction
// costs one fetch plus one access per operand, indirect read and pop from a
// non-empty stack. After reset the whole heap is cleared, one byte per cycle,
// while in_stall stays high. When the receiver stalls, a finished result
// waits in the output register; the next request is still taken and runs,
// and only its own result waits for the register.
module multithread_stack_bytecode_vm #(
    parameter int HEAP_BYTES   = 256,
    parameter int STACK_DEPTH  = 16,
    parameter int THREAD_COUNT = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  mtsbvm_pkg::in_t    in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output mtsbvm_pkg::out_t   out_data
);
    import mtsbvm_pkg::*;

    localparam int HAW = (HEAP_BYTES > 1) ? $clog2(HEAP_BYTES) : 1;
    localparam int SAW = (THREAD_COUNT * STACK_DEPTH > 1) ?
                         $clog2(THREAD_COUNT * STACK_DEPTH) : 1;
    localparam int FW  = $clog2(STACK_DEPTH + 1);
    localparam int TW  = $clog2(THREAD_COUNT + 1);
    localparam int TIW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_THR   = 4'd2;
    localparam logic [3:0] S_FETCH = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_OPND  = 4'd5;
    localparam logic [3:0] S_OPNDW = 4'd6;
    localparam logic [3:0] S_IND   = 4'd7;
    localparam logic [3:0] S_INDW  = 4'd8;
    localparam logic [3:0] S_POP   = 4'd9;
    localparam logic [3:0] S_POPW  = 4'd10;
    localparam logic [3:0] S_EXEC  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;
    localparam logic [3:0] S_RDW   = 4'd13;

    // Reduces a 9-bit address sum modulo the heap size by restoring
    // subtraction of the shifted heap size.
    function automatic logic [HAW-1:0] hmod(input logic [8:0] x);
        logic [13:0] r;
        r = {5'd0, x};
        for (int k = 4; k >= 0; k--)
        begin
            if (r >= 14'(HEAP_BYTES << k))
                r = r - 14'(HEAP_BYTES << k);
        end
        return r[HAW-1:0];
    endfunction

    function automatic logic [SAW-1:0] saddr(input logic [TIW-1:0] t,
                                              input logic [FW-1:0] f);
        return SAW'(int'(t) * STACK_DEPTH + int'(f));
    endfunction

    logic [3:0]    state_reg, state_next;
    logic [3:0]    mask_reg, mask_next;
    logic [7:0]    start_reg [4];
    logic [7:0]    start_next [4];
    logic [7:0]    base_reg [THREAD_COUNT];
    logic [7:0]    base_next [THREAD_COUNT];
    logic [7:0]    pc_reg [THREAD_COUNT];
    logic [7:0]    pc_next [THREAD_COUNT];
    logic [FW-1:0] fill_reg [THREAD_COUNT];
    logic [FW-1:0] fill_next [THREAD_COUNT];
    logic [1:0]    motor_reg, motor_next;
    logic [TW-1:0] thr_reg, thr_next;
    logic [7:0]    op_reg, op_next;
    ctl_t          ctl_reg, ctl_next;
    logic [1:0]    ind_cnt_reg, ind_cnt_next;
    logic [1:0]    pop_cnt_reg, pop_cnt_next;
    logic [7:0]    d_reg, d_next;
    logic [7:0]    v_reg, v_next;
    logic [7:0]    a_reg, a_next;
    logic [7:0]    b_reg, b_next;
    logic          eye_l_reg, eye_l_next;
    logic          eye_r_reg, eye_r_next;
    logic [7:0]    rd_reg, rd_next;
    logic [HAW-1:0] clr_reg, clr_next;
    logic          out_valid_reg, out_valid_next;
    out_t          out_reg, out_next;

    logic [7:0]     heap_mem [HEAP_BYTES];
    logic [7:0]     heap_q;
    logic           hw_en;
    logic [HAW-1:0] hw_addr, hr_addr;
    logic [7:0]     hw_data;

    logic [7:0]     stack_mem [THREAD_COUNT * STACK_DEPTH];
    logic [7:0]     stack_q;
    logic           sw_en;
    logic [SAW-1:0] sw_addr, sr_addr;
    logic [7:0]     sw_data;

    logic [TIW-1:0] t;
    logic [7:0]     base_t, pc_t;
    logic [FW-1:0]  fill_t;
    logic [7:0]     res;
    logic           push_en;
    ctl_t           dec_ctl;

    assign t       = thr_reg[TIW-1:0];
    assign base_t  = base_reg[t];
    assign pc_t    = pc_reg[t];
    assign fill_t  = fill_reg[t];
    assign dec_ctl = decode(heap_q);

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (hw_en)
            heap_mem[hw_addr] <= hw_data;
        heap_q <= heap_mem[hr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (sw_en)
            stack_mem[sw_addr] <= sw_data;
        stack_q <= stack_mem[sr_addr];
    end

    // Shared unit: the result of the current instruction.
    always_comb
    begin
        case (op_reg)
            OP_EQU:            res = (a_reg == b_reg) ? 8'd1 : 8'd0;
            OP_PSHL:           res = d_reg;
            OP_PSH, OP_PSHI:   res = v_reg;
            OP_ADD:            res = a_reg + b_reg;
            OP_SUB:            res = a_reg - b_reg;
            OP_INC:            res = a_reg + 8'd1;
            OP_DEC:            res = a_reg - 8'd1;
            OP_AND:            res = a_reg & b_reg;
            OP_OR:             res = a_reg | b_reg;
            OP_XOR:            res = a_reg ^ b_reg;
            OP_NOT:            res = ~a_reg;
            OP_ROR:            res = a_reg >> d_reg[2:0];
            OP_ROL:            res = a_reg << d_reg[2:0];
            OP_PIP:            res = v_reg + 8'd1;
            OP_PDP:            res = v_reg - 8'd1;
            OP_DUP:            res = a_reg;
            OP_LEYE:           res = {7'd0, eye_l_reg};
            OP_REYE:           res = {7'd0, eye_r_reg};
            default:           res = 8'd0;
        endcase
        case (op_reg) inside
            [OP_EQU:OP_EQU], [OP_PSHL:OP_PSHI], [OP_ADD:OP_ROL], [OP_DUP:OP_DUP],
            [OP_LEYE:OP_REYE]: push_en = 1'b1;
            default:           push_en = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mask_next      = mask_reg;
        start_next     = start_reg;
        base_next      = base_reg;
        pc_next        = pc_reg;
        fill_next      = fill_reg;
        motor_next     = motor_reg;
        thr_next       = thr_reg;
        op_next        = op_reg;
        ctl_next       = ctl_reg;
        ind_cnt_next   = ind_cnt_reg;
        pop_cnt_next   = pop_cnt_reg;
        d_next         = d_reg;
        v_next         = v_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        eye_l_next     = eye_l_reg;
        eye_r_next     = eye_r_reg;
        rd_next        = rd_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        hw_en          = 1'b0;
        hw_addr        = '0;
        hw_data        = 8'd0;
        hr_addr        = '0;
        sw_en          = 1'b0;
        sw_addr        = saddr(t, fill_t);
        sw_data        = res;
        sr_addr        = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_valid)
        begin
            if (cfg_index == CFG_ACTIVE_MASK)
                mask_next = cfg_data[3:0];
            else if (cfg_index >= CFG_START0 && cfg_index <= CFG_START3)
                start_next[2'(cfg_index - CFG_START0)] = cfg_data;
        end

        case (state_reg)
            S_CLEAR:
            begin
                hw_en    = 1'b1;
                hw_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == HAW'(HEAP_BYTES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    eye_l_next = in_data.sense_left;
                    eye_r_next = in_data.sense_right;
                    case (in_data.action)
                        ACT_TICK:
                        begin
                            thr_next   = '0;
                            rd_next    = 8'd0;
                            state_next = S_THR;
                        end
                        ACT_WRITE:
                        begin
                            hw_en   = 1'b1;
                            hw_addr = hmod({1'b0, in_data.address});
                            hw_data = in_data.write_data;
                        end
                        ACT_READ:
                        begin
                            hr_addr    = hmod({1'b0, in_data.address});
                            state_next = S_RDW;
                        end
                        default:
                        begin
                            for (int i = 0; i < THREAD_COUNT; i++)
                            begin
                                base_next[i] = start_reg[i];
                                pc_next[i]   = 8'd0;
                                fill_next[i] = '0;
                            end
                        end
                    endcase
                end
            end
            S_RDW:
            begin
                rd_next    = heap_q;
                state_next = S_OUT;
            end
            S_THR:
            begin
                if (thr_reg == TW'(THREAD_COUNT))
                    state_next = S_OUT;
                else if (mask_reg[t])
                    state_next = S_FETCH;
                else
                    thr_next = thr_reg + 1'b1;
            end
            S_FETCH:
            begin
                hr_addr    = hmod({1'b0, base_t} + {1'b0, pc_t});
                pc_next[t] = pc_t + 8'd1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                op_next      = heap_q;
                ctl_next     = dec_ctl;
                ind_cnt_next = dec_ctl.nind;
                pop_cnt_next = dec_ctl.npop;
                if (dec_ctl.opnd)
                    state_next = S_OPND;
                else if (dec_ctl.npop != 2'd0)
                    state_next = S_POP;
                else
                    state_next = S_EXEC;
            end
            S_OPND:
            begin
                hr_addr    = hmod({1'b0, base_t} + {1'b0, pc_t});
                pc_next[t] = pc_t + 8'd1;
                state_next = S_OPNDW;
            end
            S_OPNDW:
            begin
                d_next = heap_q;
                v_next = heap_q;
                if (ind_cnt_reg != 2'd0)
                    state_next = S_IND;
                else if (pop_cnt_reg != 2'd0)
                    state_next = S_POP;
                else
                    state_next = S_EXEC;
            end
            S_IND:
            begin
                hr_addr      = hmod({1'b0, base_t} + {1'b0, v_reg});
                ind_cnt_next = ind_cnt_reg - 2'd1;
                state_next   = S_INDW;
            end
            S_INDW:
            begin
                v_next = heap_q;
                if (ind_cnt_reg != 2'd0)
                    state_next = S_IND;
                else if (pop_cnt_reg != 2'd0)
                    state_next = S_POP;
                else
                    state_next = S_EXEC;
            end
            S_POP:
            begin
                // An empty stack gives zero without touching the memory.
                if (fill_t == '0)
                begin
                    if (pop_cnt_reg == ctl_reg.npop)
                        a_next = 8'd0;
                    else
                        b_next = 8'd0;
                    pop_cnt_next = pop_cnt_reg - 2'd1;
                    if (pop_cnt_reg == 2'd1)
                        state_next = S_EXEC;
                end
                else
                begin
                    sr_addr = saddr(t, fill_t - 1'b1);
                    if (!ctl_reg.peek)
                        fill_next[t] = fill_t - 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                if (pop_cnt_reg == ctl_reg.npop)
                    a_next = stack_q;
                else
                    b_next = stack_q;
                pop_cnt_next = pop_cnt_reg - 2'd1;
                state_next   = (pop_cnt_reg == 2'd1) ? S_EXEC : S_POP;
            end
            S_EXEC:
            begin
                if (push_en && fill_t < FW'(STACK_DEPTH))
                begin
                    sw_en        = 1'b1;
                    fill_next[t] = fill_t + 1'b1;
                end
                case (op_reg)
                    OP_ORG:
                    begin
                        base_next[t] = base_t + pc_t - 8'd1;
                        pc_next[t]   = 8'd1;
                    end
                    OP_JMP:  pc_next[t] = d_reg;
                    OP_JMPZ:
                    begin
                        if (a_reg == 8'd0)
                            pc_next[t] = d_reg;
                    end
                    OP_POP, OP_PIP, OP_PDP:
                    begin
                        hw_en   = 1'b1;
                        hw_addr = hmod({1'b0, base_t} + {1'b0, d_reg});
                        hw_data = (op_reg == OP_POP) ? a_reg : res;
                    end
                    OP_POPI:
                    begin
                        hw_en   = 1'b1;
                        hw_addr = hmod({1'b0, base_t} + {1'b0, v_reg});
                        hw_data = a_reg;
                    end
                    OP_LMOT: motor_next[0] = ~a_reg[0];
                    OP_RMOT: motor_next[1] = ~a_reg[0];
                    default: ;
                endcase
                thr_next   = thr_reg + 1'b1;
                state_next = S_THR;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next        = 1'b1;
                    out_next.motor_left   = motor_reg[0];
                    out_next.motor_right  = motor_reg[1];
                    out_next.read_data    = rd_reg;
                    state_next            = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mask_reg      <= '0;
            start_reg     <= '{default: '0};
            base_reg      <= '{default: '0};
            pc_reg        <= '{default: '0};
            fill_reg      <= '{default: '0};
            motor_reg     <= '0;
            thr_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            start_reg     <= start_next;
            base_reg      <= base_next;
            pc_reg        <= pc_next;
            fill_reg      <= fill_next;
            motor_reg     <= motor_next;
            thr_reg       <= thr_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ctl_reg     <= ctl_next;
        ind_cnt_reg <= ind_cnt_next;
        pop_cnt_reg <= pop_cnt_next;
        d_reg       <= d_next;
        v_reg       <= v_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        eye_l_reg   <= eye_l_next;
        eye_r_reg   <= eye_r_next;
        rd_reg      <= rd_next;
        out_reg     <= out_next;
    end

    a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result appeared outside the output state");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[0] <= FW'(STACK_DEPTH))
        else $error("stack fill beyond depth");

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("request taken during heap clear");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the multithreaded byte-coded stack machine.
`timescale 1ns / 100ps

module tb_top;
    import mtsbvm_pkg::*;

    localparam int HEAP_BYTES   = 256;
    localparam int STACK_DEPTH  = 16;
    localparam int THREAD_COUNT = 4;
    localparam int MAX_SHOWN    = 10;
    localparam logic [7:0] OP_NOP_FILL = 8'd200;

    logic     clk;
    logic     rst_n;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    logic     in_valid;
    logic     in_stall;
    in_t      in_data;
    logic     out_valid;
    logic     out_stall;
    out_t     out_data;

    multithread_stack_bytecode_vm #(
        .HEAP_BYTES  (HEAP_BYTES),
        .STACK_DEPTH (STACK_DEPTH),
        .THREAD_COUNT(THREAD_COUNT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    // Shadow copy of the machine: configuration, heap, threads and stacks.
    logic [3:0] vm_mask;
    logic [7:0] vm_start [THREAD_COUNT];
    logic [7:0] vm_heap [HEAP_BYTES];
    logic [7:0] vm_base [THREAD_COUNT];
    logic [7:0] vm_pc [THREAD_COUNT];
    logic [7:0] vm_stack [THREAD_COUNT][STACK_DEPTH];
    int         vm_fill [THREAD_COUNT];
    logic [1:0] vm_motor;

    out_t motor_results[$];
    int   mismatches;
    int   results_seen;
    int   ticks_sent;
    int   send_idle_pct;
    int   recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Timeout waiting for the machine to finish");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] heap_rd(int t, logic [7:0] off);
        return vm_heap[8'(vm_base[t] + off)];
    endfunction

    function automatic void heap_wr(int t, logic [7:0] off, logic [7:0] v);
        vm_heap[8'(vm_base[t] + off)] = v;
    endfunction

    function automatic void push(int t, logic [7:0] v);
        if (vm_fill[t] < STACK_DEPTH)
        begin
            vm_stack[t][vm_fill[t]] = v;
            vm_fill[t]++;
        end
    endfunction

    function automatic logic [7:0] pop(int t);
        if (vm_fill[t] == 0)
            return 8'd0;
        vm_fill[t]--;
        return vm_stack[t][vm_fill[t]];
    endfunction

    function automatic logic [7:0] fetch(int t);
        logic [7:0] v;
        v = heap_rd(t, vm_pc[t]);
        vm_pc[t] = vm_pc[t] + 8'd1;
        return v;
    endfunction

    // Runs one instruction of thread t.
    function automatic void run_instruction(int t, logic leye, logic reye);
        logic [7:0] op;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] d;
        op = fetch(t);
        case (op)
            OP_ORG:
            begin
                vm_base[t] = vm_base[t] + vm_pc[t] - 8'd1;
                vm_pc[t] = 8'd1;
            end
            OP_EQU:
            begin
                a = pop(t);
                b = pop(t);
                push(t, (a == b) ? 8'd1 : 8'd0);
            end
            OP_JMP:  vm_pc[t] = heap_rd(t, vm_pc[t]);
            OP_JMPZ:
            begin
                if (pop(t) == 8'd0)
                    vm_pc[t] = heap_rd(t, vm_pc[t]);
                else
                    vm_pc[t] = vm_pc[t] + 8'd1;
            end
            OP_PSHL: push(t, fetch(t));
            OP_PSH:  push(t, heap_rd(t, fetch(t)));
            OP_PSHI: push(t, heap_rd(t, heap_rd(t, fetch(t))));
            OP_POP:
            begin
                d = fetch(t);
                heap_wr(t, d, pop(t));
            end
            OP_POPI:
            begin
                d = heap_rd(t, fetch(t));
                heap_wr(t, d, pop(t));
            end
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR:
            begin
                a = pop(t);
                b = pop(t);
                case (op)
                    OP_ADD:  push(t, a + b);
                    OP_SUB:  push(t, a - b);
                    OP_AND:  push(t, a & b);
                    OP_OR:   push(t, a | b);
                    default: push(t, a ^ b);
                endcase
            end
            OP_INC:  push(t, pop(t) + 8'd1);
            OP_DEC:  push(t, pop(t) - 8'd1);
            OP_NOT:  push(t, ~pop(t));
            OP_ROR:
            begin
                a = pop(t);
                d = fetch(t);
                push(t, a >> d[2:0]);
            end
            OP_ROL:
            begin
                a = pop(t);
                d = fetch(t);
                push(t, a << d[2:0]);
            end
            OP_PIP:
            begin
                d = fetch(t);
                heap_wr(t, d, heap_rd(t, d) + 8'd1);
            end
            OP_PDP:
            begin
                d = fetch(t);
                heap_wr(t, d, heap_rd(t, d) - 8'd1);
            end
            OP_DUP:  push(t, (vm_fill[t] == 0) ? 8'd0 : vm_stack[t][vm_fill[t] - 1]);
            // Motor bits are active low: an odd byte clears the bit.
            OP_LMOT: vm_motor[0] = ~pop(t) & 1'b1 ? 1'b1 : 1'b0;
            OP_RMOT: vm_motor[1] = ~pop(t) & 1'b1 ? 1'b1 : 1'b0;
            OP_LEYE: push(t, {7'd0, leye});
            OP_REYE: push(t, {7'd0, reye});
            default: ;
        endcase
    endfunction

    // Applies one accepted request to the shadow machine and queues its result, for a tick or a read.
    function automatic void predict_request(in_t req);
        out_t r;
        case (req.action)
            ACT_TICK:
            begin
                for (int t = 0; t < THREAD_COUNT; t++)
                    if (vm_mask[t])
                        run_instruction(t, req.sense_left, req.sense_right);
                r.motor_left  = vm_motor[0];
                r.motor_right = vm_motor[1];
                r.read_data   = 8'd0;
                motor_results.push_back(r);
            end
            ACT_WRITE: vm_heap[req.address] = req.write_data;
            ACT_READ:
            begin
                r.motor_left  = vm_motor[0];
                r.motor_right = vm_motor[1];
                r.read_data   = vm_heap[req.address];
                motor_results.push_back(r);
            end
            default:
                for (int t = 0; t < THREAD_COUNT; t++)
                begin
                    vm_base[t] = vm_start[t];
                    vm_pc[t] = 8'd0;
                    vm_fill[t] = 0;
                end
        endcase
    endfunction

    // Receiver: random stall, compare each accepted result with the oldest one queued.
    always @(negedge clk)
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (motor_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("Unexpected result %h", out_data);
            end
            else
            begin
                want = motor_results.pop_front();
                if (out_data.motor_left !== want.motor_left
                    || out_data.motor_right !== want.motor_right
                    || out_data.read_data !== want.read_data)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("Mismatch: expected lm=%b rm=%b data=%h, got lm=%b rm=%b data=%h",
                                 want.motor_left, want.motor_right, want.read_data,
                                 out_data.motor_left, out_data.motor_right,
                                 out_data.read_data);
                end
            end
        end
    end

    // Sends one request with a random lead-in gap and waits for it to be taken.
    // The request stays driven after it is taken until the caller either sends
    // the next one or drops in_valid.
    task automatic send_request(in_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(req);
        if (req.action == ACT_TICK)
            ticks_sent++;
        @(negedge clk);
    endtask

    // Waits until every result has arrived, then lets in-flight work settle.
    task automatic drain;
        in_valid <= 1'b0;
        while (motor_results.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // Writes one configuration register; only called while the machine is idle.
    task automatic write_register(logic [2:0] idx, logic [7:0] value);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_ACTIVE_MASK)
            vm_mask = value[3:0];
        else
            vm_start[idx - CFG_START0] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic in_t make_req(logic [1:0] act, logic [7:0] addr, logic [7:0] wd,
                                     logic le, logic re);
        in_t r;
        r.action      = act;
        r.address     = addr;
        r.write_data  = wd;
        r.sense_left  = le;
        r.sense_right = re;
        return r;
    endfunction

    // Loads a short random program for each thread, picks a random active mask and restarts them all.
    task automatic load_programs();
        logic [7:0] base;
        for (int t = 0; t < THREAD_COUNT; t++)
        begin
            base = 8'(t * 64 + $urandom_range(0, 8));
            write_register(CFG_START0 + 3'(t), base);
            for (int k = 0; k < 24; k++)
            begin
                logic [7:0] b;
                // Mostly valid opcodes, some small operands and odd bytes.
                case ($urandom_range(9))
                    0:       b = 8'($urandom_range(0, 255));
                    1, 2:    b = 8'($urandom_range(0, 30));
                    default: b = 8'($urandom_range(1, 26));
                endcase
                if (k == 23)
                    b = OP_JMP;
                send_request(make_req(ACT_WRITE, base + 8'(k), b, 1'b0, 1'b0));
            end
            send_request(make_req(ACT_WRITE, base + 8'd24, 8'd0, 1'b0, 1'b0));
        end
        write_register(CFG_ACTIVE_MASK, 8'($urandom_range(1, 15)));
        send_request(make_req(ACT_RESTART, 8'd0, 8'd0, 1'b0, 1'b0));
    endtask

    // Directed requests: host access at the address extremes. A hand-made program that holds
    // every opcode, including an unknown one, follows them.
    typedef struct {
        in_t      req;
        bit       typed;
        out_t     want;
    } directed_row_t;

    directed_row_t directed[$];

    function automatic void add_row(in_t req, bit typed, out_t want);
        directed_row_t row;
        row.req = req;
        row.typed = typed;
        row.want = want;
        directed.push_back(row);
    endfunction

    initial
    begin
        logic [7:0] prog [$];
        out_t zero_out;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        mismatches = 0;
        results_seen = 0;
        ticks_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        vm_mask = '0;
        vm_motor = '0;
        for (int i = 0; i < HEAP_BYTES; i++)
            vm_heap[i] = '0;
        for (int t = 0; t < THREAD_COUNT; t++)
        begin
            vm_start[t] = '0;
            vm_base[t] = '0;
            vm_pc[t] = '0;
            vm_fill[t] = 0;
        end
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // The heap reads as zero after reset, and a tick with nothing active
        // leaves both motor bits low; bytes written at both ends then read back.
        zero_out = '0;
        add_row(make_req(ACT_READ, 8'd0, 8'd0, 1'b0, 1'b0), 1'b1, zero_out);
        add_row(make_req(ACT_READ, 8'd255, 8'd0, 1'b1, 1'b1), 1'b1, zero_out);
        add_row(make_req(ACT_TICK, 8'd0, 8'd0, 1'b1, 1'b1), 1'b1, zero_out);
        add_row(make_req(ACT_WRITE, 8'd255, 8'd255, 1'b0, 1'b0), 1'b0, zero_out);
        add_row(make_req(ACT_READ, 8'd255, 8'd0, 1'b0, 1'b0), 1'b1,
                '{1'b0, 1'b0, 8'd255});
        add_row(make_req(ACT_WRITE, 8'd0, 8'hA5, 1'b0, 1'b0), 1'b0, zero_out);
        add_row(make_req(ACT_READ, 8'd0, 8'd0, 1'b0, 1'b0), 1'b1,
                '{1'b0, 1'b0, 8'hA5});
        foreach (directed[i])
        begin
            send_request(directed[i].req);
            if (directed[i].typed && motor_results.size() != 0
                && motor_results[$] != directed[i].want)
            begin
                mismatches++;
                $display("Directed row %0d predicts %h, table says %h", i,
                         motor_results[$], directed[i].want);
            end
        end
        drain();

        // Program at base 0x40 for thread 0 holding every opcode, with a few
        // pops past empty.
        prog = '{OP_LEYE, OP_REYE, OP_EQU, OP_PSHL, 8'hFF, OP_DUP, OP_ADD, OP_INC,
                 OP_DEC, OP_NOT, OP_PSHL, 8'h0F, OP_AND, OP_PSHL, 8'h30, OP_OR,
                 OP_PSHL, 8'h81, OP_XOR, OP_ROR, 8'd9, OP_ROL, 8'd15, OP_POP, 8'd80,
                 OP_PSH, 8'd80, OP_PSHI, 8'd82, OP_POPI, 8'd82, OP_PIP, 8'd80,
                 OP_PDP, 8'd81, OP_SUB, OP_SUB, OP_LMOT, OP_RMOT, OP_PSHL, 8'd1,
                 OP_LMOT, OP_PSHL, 8'd3, OP_RMOT, OP_JMPZ, 8'd60, 8'd200, OP_PSHL,
                 8'd5, OP_JMPZ, 8'd0, OP_ORG, OP_NOP_FILL, OP_JMP, 8'd0};
        write_register(CFG_START0, 8'h40);
        write_register(CFG_START0 + 3'd1, 8'hFF);
        write_register(CFG_START0 + 3'd2, 8'h00);
        write_register(CFG_START3, 8'h80);
        write_register(CFG_ACTIVE_MASK, 8'd1);
        foreach (prog[i])
            send_request(make_req(ACT_WRITE, 8'h40 + 8'(i), prog[i], 1'b0, 1'b0));
        send_request(make_req(ACT_WRITE, 8'h82, 8'd81, 1'b0, 1'b0));
        send_request(make_req(ACT_RESTART, 8'd0, 8'd0, 1'b0, 1'b0));
        for (int i = 0; i < 45; i++)
            send_request(make_req(ACT_TICK, 8'd0, 8'd0, 1'(i), 1'(i >> 1)));
        // Thread 3 runs a line of DUPs; its full stack drops further pushes.
        drain();
        write_register(CFG_START3, 8'h90);
        write_register(CFG_ACTIVE_MASK, 8'd15);
        for (int i = 0; i < 20; i++)
            send_request(make_req(ACT_WRITE, 8'h90 + 8'(i), OP_DUP, 1'b0, 1'b0));
        send_request(make_req(ACT_RESTART, 8'd0, 8'd0, 1'b0, 1'b0));
        for (int i = 0; i < 20; i++)
            send_request(make_req(ACT_TICK, 8'd0, 8'd0, 1'b1, 1'b0));
        drain();

        // Random phases: each loads fresh programs, then mixes ticks with host traffic.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 79;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            drain();
            load_programs();
            for (int i = 0; i < 60; i++)
            begin
                case ($urandom_range(19))
                    0:  send_request(make_req(ACT_WRITE, 8'($urandom), 8'($urandom),
                                              1'($urandom), 1'($urandom)));
                    1, 2: send_request(make_req(ACT_READ, 8'($urandom), 8'($urandom),
                                                1'($urandom), 1'($urandom)));
                    3:  send_request(make_req(ACT_RESTART, 8'($urandom), 8'($urandom),
                                              1'($urandom), 1'($urandom)));
                    default: send_request(make_req(ACT_TICK, 8'($urandom), 8'($urandom),
                                                   1'($urandom), 1'($urandom)));
                endcase
                // Hold off once until the machine has nothing outstanding.
                if (phase == 2 && i == 40)
                begin
                    in_valid <= 1'b0;
                    while (motor_results.size() != 0)
                        @(negedge clk);
                    @(negedge clk);
                end
            end
            if (phase == 4)
            begin
                drain();
                write_register(CFG_ACTIVE_MASK, 8'd0);
                write_register(CFG_START3, 8'd255);
            end
        end

        drain();
        $display("Ran %0d ticks and %0d checked results over random programs,",
                 ticks_sent, results_seen);
        $display("with active masks from none to all four threads and varied idling.");
        if (mismatches == 0 && motor_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mtsbvm_pkg.sv
hw/rtl/multithread_stack_bytecode_vm.sv
tb/tb_top.sv
